### hdl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    // request operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // configuration register map
    localparam logic REG_CAPACITY = 1'b0;
    localparam int   CAP_W        = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // field widths
    localparam int KEY_W  = 64;
    localparam int SLOT_W = 10;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LREAD,
        ST_LUNL,
        ST_LFRONT,
        ST_LFRONT2,
        ST_DONE
    } t_lkv_state;

endpackage

`default_nettype wire

### hdl/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// Valid/ready channels for cache requests and get responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkv_req_if;
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic signed [63:0]      key;
    logic signed [63:0]      value;

    modport source (output valid, operation, key, value, input ready);
    modport sink   (input valid, operation, key, value, output ready);
endinterface

interface lkv_rsp_if;
    logic                    valid;
    logic                    ready;
    logic        [9:0]       slot;
    logic signed [63:0]      data;

    modport source (output valid, slot, data, input ready);
    modport sink   (input valid, slot, data, output ready);
endinterface

`default_nettype wire

### hdl/lkv_cfg.sv
// ----------------------------------------------------------------------------
// lkv_cfg
// APB register block holding the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic      [lkv_pkg::CAP_W-1:0] o_capacity
);
    import lkv_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

    // capacity register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (wr_en) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = {{(32-CAP_W){1'b0}}, r_capacity};
        end
    end

    assign o_capacity = r_capacity;

endmodule

`default_nettype wire

### hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
//
// Channels: i_req carries get/put requests (operation, key, value); o_rsp
// returns slot and data for every get, nothing for a put. One transfer on
// i_req is processed at a time. The key search walks the key memory one
// slot per cycle over the filled slots, then the recency list is relinked
// through the link memories; the time an item takes is set by the key scan
// over the single key memory read port.
// The response is held in an output register; while an earlier response
// still waits there, a stalled receiver holds the cache in its final state,
// but a new request can be taken while the latest response waits.
// Reset clears the fill count and the recency list head and tail; the slot
// memories need no clearing. Capacity is set over the APB port (byte
// address 0), reset value 1024, clamped to 1..ENTRIES.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lkv_req_if.sink          i_req,
    lkv_rsp_if.source        o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import lkv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = IW + 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

    // memories
    logic signed [KEY_W-1:0] key_mem   [ENTRIES];
    logic signed [KEY_W-1:0] val_mem   [ENTRIES];
    logic        [LW-1:0]    older_mem [ENTRIES];
    logic        [LW-1:0]    newer_mem [ENTRIES];

    logic signed [KEY_W-1:0] key_rdata, val_rdata;
    logic        [LW-1:0]    older_rdata, newer_rdata;

    logic [CAP_W-1:0] capacity;

    // state
    t_lkv_state r_state, n_state;
    logic                    r_op;
    logic signed [KEY_W-1:0] r_key, r_val, r_data;
    logic [IW-1:0]           r_idx, r_s;
    logic                    r_hit, r_new;
    logic [LW-1:0]           r_mr, r_lr;
    logic [FW-1:0]           r_fill;
    logic                    r_out_valid;
    logic [SLOT_W-1:0]       r_out_slot;
    logic signed [KEY_W-1:0] r_out_data;

    // memory port controls
    logic [IW-1:0]           key_raddr;
    logic                    key_we, val_we, older_we, newer_we;
    logic signed [KEY_W-1:0] val_wdata;
    logic [IW-1:0]           older_waddr, newer_waddr;
    logic [LW-1:0]           older_wdata, newer_wdata;

    // derived
    logic [31:0]   cap32, cap_eff, fill32, idx_next32, s32;
    logic          miss_new, key_match, scan_more, accept, out_free;
    logic [IW-1:0] miss_slot;

    lkv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // effective capacity and miss slot choice
    assign cap32      = {{(32-CAP_W){1'b0}}, capacity};
    assign cap_eff    = (cap32 == 32'd0) ? 32'd1 :
                        (cap32 > 32'(ENTRIES)) ? 32'(ENTRIES) : cap32;
    assign fill32     = 32'(r_fill);
    assign miss_new   = fill32 < cap_eff;
    assign miss_slot  = miss_new ? fill32[IW-1:0] :
                        (r_lr[IW] ? '0 : r_lr[IW-1:0]);
    assign idx_next32 = 32'(r_idx) + 32'd1;
    assign scan_more  = idx_next32 < fill32;
    assign key_match  = (key_rdata == r_key);
    assign accept     = i_req.valid && i_req.ready;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign s32        = 32'(r_s);

    assign i_req.ready = (r_state == ST_IDLE);
    assign key_raddr   = (r_state == ST_SCAN) ? idx_next32[IW-1:0] : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (accept) n_state = (r_fill == '0) ? ST_LREAD : ST_SCAN;
            ST_SCAN:    if (key_match || !scan_more) n_state = ST_LREAD;
            ST_LREAD:   n_state = ST_LUNL;
            ST_LUNL:    n_state = (r_hit && r_mr == {1'b0, r_s}) ? ST_DONE : ST_LFRONT;
            ST_LFRONT:  n_state = ST_LFRONT2;
            ST_LFRONT2: n_state = ST_DONE;
            ST_DONE:    if (r_op == OP_PUT || out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory write controls
    always_comb begin
        key_we      = 1'b0;
        val_we      = 1'b0;
        val_wdata   = (r_op == OP_PUT) ? r_val : '0;
        older_we    = 1'b0;
        older_waddr = r_s;
        older_wdata = r_mr;
        newer_we    = 1'b0;
        newer_waddr = r_s;
        newer_wdata = NIL;
        unique case (r_state)
            ST_LREAD: begin
                key_we = !r_hit;
                val_we = !r_hit || (r_op == OP_PUT);
            end
            ST_LUNL: begin
                if (!(r_hit && r_mr == {1'b0, r_s}) && !r_new) begin
                    older_we    = !newer_rdata[IW];
                    older_waddr = newer_rdata[IW-1:0];
                    older_wdata = older_rdata;
                    newer_we    = !older_rdata[IW];
                    newer_waddr = older_rdata[IW-1:0];
                    newer_wdata = newer_rdata;
                end
            end
            ST_LFRONT: begin
                older_we = 1'b1;
                newer_we = 1'b1;
            end
            ST_LFRONT2: begin
                newer_we    = !r_mr[IW];
                newer_waddr = r_mr[IW-1:0];
                newer_wdata = {1'b0, r_s};
            end
            default: ;
        endcase
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[r_s] <= r_key;
        key_rdata <= key_mem[key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) val_mem[r_s] <= val_wdata;
        val_rdata <= val_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (older_we) older_mem[older_waddr] <= older_wdata;
        older_rdata <= older_mem[r_s];
    end

    always_ff @(posedge i_clk) begin
        if (newer_we) newer_mem[newer_waddr] <= newer_wdata;
        newer_rdata <= newer_mem[r_s];
    end

    // request datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.operation;
            r_key <= i_req.key;
            r_val <= i_req.value;
            r_idx <= '0;
            if (r_fill == '0) begin
                r_hit <= 1'b0;
                r_new <= miss_new;
                r_s   <= miss_slot;
            end
        end
        if (r_state == ST_SCAN) begin
            if (key_match) begin
                r_hit <= 1'b1;
                r_new <= 1'b0;
                r_s   <= r_idx;
            end else if (scan_more) begin
                r_idx <= idx_next32[IW-1:0];
            end else begin
                r_hit <= 1'b0;
                r_new <= miss_new;
                r_s   <= miss_slot;
            end
        end
        if (r_state == ST_LUNL) begin
            r_data <= (r_hit && r_op == OP_GET) ? val_rdata : '0;
        end
    end

    // list head, tail and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mr    <= NIL;
            r_lr    <= NIL;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_LUNL: begin
                    if (!(r_hit && r_mr == {1'b0, r_s}) && !r_new) begin
                        if (newer_rdata[IW]) r_mr <= older_rdata;
                        if (older_rdata[IW]) r_lr <= newer_rdata;
                    end
                end
                ST_LFRONT: begin
                    if (r_new) r_fill <= r_fill + FW'(1);
                end
                ST_LFRONT2: begin
                    if (r_mr[IW]) r_lr <= {1'b0, r_s};
                    r_mr <= {1'b0, r_s};
                end
                default: ;
            endcase
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && r_op == OP_GET && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && r_op == OP_GET && out_free) begin
            r_out_slot <= s32[SLOT_W-1:0];
            r_out_data <= r_data;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.slot  = r_out_slot;
    assign o_rsp.data  = r_out_data;

endmodule

`default_nettype wire

### sim/tb_lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench: random get/put traffic over a small key pool runs
// against a recency-list model of the cache across several capacity
// settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam int ENTRIES    = 1024;
    localparam int NIL        = -1;
    localparam int MAX_CYCLES = 1000000;
    localparam int DRAIN      = 1100;

    // recency-list model of the cache, holds the replies still to come
    class lru_recency_model;
        logic [63:0]     key_mem [ENTRIES];
        logic [63:0]     val_mem [ENTRIES];
        int              older [ENTRIES];
        int              newer [ENTRIES];
        int              head;
        int              tail;
        int              used;
        logic [CAP_W-1:0] cap_reg;
        logic [73:0]     replies [$];

        function new();
            head = NIL;
            tail = NIL;
            used = 0;
            cap_reg = CAP_RESET;
        endfunction

        function void unlink(int s);
            if (newer[s] != NIL) older[newer[s]] = older[s];
            else head = older[s];
            if (older[s] != NIL) newer[older[s]] = newer[s];
            else tail = newer[s];
        endfunction

        function void link_head(int s);
            newer[s] = NIL;
            older[s] = head;
            if (head != NIL) newer[head] = s;
            else tail = s;
            head = s;
        endfunction

        function void touch(int s);
            if (head == s) return;
            unlink(s);
            link_head(s);
        endfunction

        // one accepted request: update state, queue the reply of a get
        function void note_request(logic op, logic [63:0] key, logic [63:0] val);
            int eff;
            int s;
            eff = cap_reg;
            s = NIL;
            if (eff == 0) eff = 1;
            if (eff > ENTRIES) eff = ENTRIES;
            for (int i = 0; i < used; i++) begin
                if (key_mem[i] == key) begin
                    s = i;
                    break;
                end
            end
            if (s != NIL) begin
                touch(s);
                if (op == OP_PUT) val_mem[s] = val;
            end else begin
                if (used < eff) begin
                    s = used;
                    used++;
                    link_head(s);
                end else begin
                    s = (tail == NIL) ? 0 : tail;
                    touch(s);
                end
                key_mem[s] = key;
                val_mem[s] = (op == OP_PUT) ? val : 64'd0;
            end
            if (op == OP_GET) replies.push_back({s[9:0], val_mem[s]});
        endfunction

        // compare one reply with the oldest expected one
        function bit check_reply(logic [9:0] slot, logic [63:0] data, output string msg);
            logic [73:0] exp;
            exp = replies.pop_front();
            msg = "";
            if (exp[73:64] !== slot)
                msg = $sformatf("slot %0d, expected %0d", slot, exp[73:64]);
            if (exp[63:0] !== data)
                msg = {msg, $sformatf(" data %h, expected %h", data, exp[63:0])};
            return msg == "";
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lkv_req_if req_ch();
    lkv_rsp_if rsp_ch();

    lru_key_value_cache #(.ENTRIES(ENTRIES)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lru_recency_model cache_model = new();
    int    mismatches = 0;
    int    cycles = 0;
    bit    idle_en = 1'b1;
    logic [63:0] key_pool [32];

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("[lru_key_value_cache] ERROR");
            $finish;
        end
    end

    // reply side: check each transfer, stall in random bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        string msg;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (cache_model.replies.size() == 0)
                report("reply with nothing expected");
            else if (!cache_model.check_reply(rsp_ch.slot, rsp_ch.data, msg))
                report(msg);
        end
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (stall_left > 0 && idle_en) begin
            rsp_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = 0;
            if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
        end
    end

    task automatic write_capacity(input logic [31:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_CAPACITY);
        pwdata  <= cap;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cache_model.cap_reg = cap[CAP_W-1:0];
    endtask

    // one request transfer, with an optional idle burst ahead of it
    task automatic send_request(input logic op, input logic [63:0] key,
                                input logic [63:0] val);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= key;
        req_ch.value     <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        cache_model.note_request(op, key, val);
    endtask

    // let every reply arrive and any put finish before a register write
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (cache_model.replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    initial begin
        int caps [10];
        int pool_n;
        logic [63:0] key;
        caps             = '{1, 2, 4, 8, 16, 3, 0, 2047, 1024, 5};
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_GET;
        req_ch.key       <= '0;
        req_ch.value     <= '0;
        key_pool[0] = 64'h8000_0000_0000_0000;
        key_pool[1] = 64'h7FFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < 32; i++) key_pool[i] = {$urandom, $urandom};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: key and value extremes, hit on most recent, put then get
        send_request(OP_GET, 64'h8000_0000_0000_0000, 64'h0);
        send_request(OP_GET, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_GET, 64'h0, 64'h0);
        send_request(OP_GET, 64'h0, 64'h0);
        send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_request(OP_PUT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_request(OP_GET, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0);
        send_request(OP_PUT, 64'h1234, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(OP_GET, 64'h1234, 64'h0);
        send_request(OP_PUT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_GET, 64'h8000_0000_0000_0000, 64'h0);
        send_request(OP_GET, 64'h0, 64'h0);

        // random phases over capacity settings, the last without idling
        foreach (caps[p]) begin
            drain();
            write_capacity(caps[p]);
            if (p == 9) idle_en = 1'b0;
            pool_n = (caps[p] == 0) ? 3 : ((2 * caps[p] + 3 > 32) ? 32 : 2 * caps[p] + 3);
            for (int n = 0; n < 130; n++) begin
                if (p == 2 && n == 60) begin
                    req_ch.valid <= 1'b0;
                    while (cache_model.replies.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
                else key = key_pool[$urandom_range(0, pool_n - 1)];
                send_request($urandom_range(0, 1) ? OP_PUT : OP_GET, key,
                             {$urandom, $urandom});
            end
        end
        req_ch.valid <= 1'b0;

        // wait out the last replies
        while (cache_model.replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0)
            $display("[lru_key_value_cache] OK");
        else
            $display("[lru_key_value_cache] ERROR");
        $finish;
    end
endmodule

### lru_key_value_cache.f
hdl/lkv_pkg.sv
hdl/lkv_if.sv
hdl/lkv_cfg.sv
hdl/lru_key_value_cache.sv
sim/tb_lru_key_value_cache.sv
